// ----- rtl/smap_pkg.sv -----
// Package for the sequential id mapper: item types, width codes and the
// key forming function for the front and the id truncation function for the back.
// Depends on nothing.
`default_nettype none

package smap_pkg;

  localparam int KEY_W = 32;
  localparam int ID_W = 32;
  // Widest bucket index that the BUCKETS parameter range needs.
  localparam int BUCKET_IDX_W = 16;

  localparam logic [1:0] WIDTH_BYTE = 2'd0;
  localparam logic [1:0] WIDTH_HALF = 2'd1;
  localparam logic [1:0] WIDTH_WORD = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key_bits;
    logic [1:0]       field_width;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] mapped_id;
    logic            is_new;
    logic            bucket_full;
  } out_item_t;

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic [1:0]              code;
    logic [BUCKET_IDX_W-1:0] bucket;
  } job_t;

  function automatic logic [KEY_W-1:0] form_key(input logic [KEY_W-1:0] raw,
                                                input logic [1:0] code);
    logic [KEY_W-1:0] k;
    case (code)
      WIDTH_HALF: k = {{16{raw[15]}}, raw[15:0]};
      WIDTH_WORD: k = raw;
      default:    k = {24'd0, raw[7:0]};
    endcase
    return k;
  endfunction

  function automatic logic [ID_W-1:0] trunc_id(input logic [ID_W-1:0] id,
                                               input logic [1:0] code);
    logic [ID_W-1:0] t;
    case (code)
      WIDTH_HALF: t = {16'd0, id[15:0]};
      WIDTH_WORD: t = id;
      default:    t = {24'd0, id[7:0]};
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/smap_fifo.sv -----
// Two-entry queue that holds classified items between the front and back.
// Generic over the payload width; no package dependency.
`default_nettype none

module smap_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/smap_front.sv -----
// Front part: takes items, forms the key and works out its bucket index.
// Uses smap_pkg; feeds smap_fifo.
`default_nettype none

module smap_front #(
  parameter int BUCKETS = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  smap_pkg::in_item_t item,
  input  logic              hold,
  output logic              push_valid,
  input  logic              push_ready,
  output smap_pkg::job_t    push_data
);
  import smap_pkg::*;

  localparam int BB = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int RW = BB + 1;
  localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam int PW = 2 * KEY_W;
  localparam logic [PW-1:0] RECIP_FULL = (PW'(1) << KEY_W) / PW'(BUCKETS);
  localparam logic [KEY_W-1:0] RECIP = RECIP_FULL[KEY_W-1:0];

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t          state;
  logic [KEY_W-1:0] key;
  logic [1:0]       code;
  logic [BB-1:0]    rem;
  logic [KEY_W-1:0] quo;
  logic [RW-1:0]    rem_est;
  logic [1:0]       step;
  logic [KEY_W-1:0] new_key;
  logic [PW-1:0]    prod;
  logic [KEY_W-1:0] diff;
  logic             accept;

  assign busy    = (state != F_IDLE) || hold;
  assign accept  = start && !busy;
  assign new_key = form_key(item.key_bits, item.field_width);

  // The reciprocal is rounded down, so the quotient estimate is at most one
  // short and the estimated remainder needs at most one subtraction.
  assign prod = PW'(key) * PW'(RECIP);
  assign diff = key - quo * KEY_W'(BUCKETS);

  assign push_valid       = (state == F_PUSH);
  assign push_data.key    = key;
  assign push_data.code   = code;
  assign push_data.bucket = BUCKET_IDX_W'(rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            key  <= new_key;
            code <= item.field_width;
            step <= '0;
            if (IS_POW2) begin
              rem   <= BB'(new_key & 32'(BUCKETS - 1));
              state <= F_PUSH;
            end else begin
              rem   <= '0;
              state <= F_DIV;
            end
          end
        end
        F_DIV: begin
          step <= step + 2'd1;
          if (step == 2'd0) begin
            quo <= prod[PW-1:KEY_W];
          end else if (step == 2'd1) begin
            rem_est <= diff[RW-1:0];
          end else begin
            rem   <= (rem_est >= RW'(BUCKETS)) ? BB'(rem_est - RW'(BUCKETS))
                                               : rem_est[BB-1:0];
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/smap_back.sv -----
// Back part: searches a bucket's ways, inserts on a miss if a way is free
// and drives results. Uses smap_pkg; takes classified items from smap_fifo.
`default_nettype none

module smap_back #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  smap_pkg::job_t     pop_data,
  input  logic               cfg_write,
  input  logic [31:0]        cfg_data,
  output logic               clearing,
  output logic               done,
  output smap_pkg::out_item_t result
);
  import smap_pkg::*;

  localparam int BB    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SLOTS = BUCKETS * WAYS;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WCW   = $clog2(WAYS + 1);

  typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_SCAN} bstate_t;

  logic [KEY_W-1:0] key_mem [SLOTS];
  logic [ID_W-1:0]  id_mem [SLOTS];
  logic [WAYS-1:0]  vrow_mem [BUCKETS];

  bstate_t          state;
  logic [KEY_W-1:0] key_q;
  logic [1:0]       code_q;
  logic [BB-1:0]    bucket_q;
  logic [WCW-1:0]   iw;
  logic             chk_pend;
  logic [WW-1:0]    chk_way;
  logic [BB-1:0]    clr_cnt;
  logic [ID_W-1:0]  next_id;
  logic [KEY_W-1:0] key_rd;
  logic [ID_W-1:0]  id_rd;
  logic [WAYS-1:0]  vrow_rd;

  logic [WW-1:0]    way_sel;
  logic [SW-1:0]    rd_slot;
  logic [SW-1:0]    wr_slot;
  logic             hit;
  logic             miss_now;
  logic             free_found;
  logic [WW-1:0]    free_way;
  logic             ins;
  logic             v_we;
  logic [BB-1:0]    v_waddr;
  logic [WAYS-1:0]  v_wdata;
  logic [BB-1:0]    v_raddr;
  logic [WAYS-1:0]  free_mask;

  assign clearing  = (state == B_CLEAR);
  assign pop_ready = (state == B_IDLE);

  assign way_sel = (iw < WCW'(WAYS)) ? iw[WW-1:0] : '0;
  assign rd_slot = SW'(32'(bucket_q) * WAYS + 32'(way_sel));
  assign wr_slot = SW'(32'(bucket_q) * WAYS + 32'(free_way));

  // Lowest way whose valid bit is clear.
  always_comb begin
    free_found = 1'b0;
    free_way   = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!vrow_rd[w]) begin
        free_found = 1'b1;
        free_way   = WW'(w);
      end
    end
  end

  always_comb begin
    free_mask = '0;
    free_mask[free_way] = 1'b1;
  end

  assign hit      = (state == B_SCAN) && chk_pend && vrow_rd[chk_way] && (key_rd == key_q);
  assign miss_now = (state == B_SCAN) && !hit && (iw == WCW'(WAYS));
  assign ins      = miss_now && free_found;

  assign v_we    = clearing || ins;
  assign v_waddr = clearing ? clr_cnt : bucket_q;
  assign v_wdata = clearing ? '0 : (vrow_rd | free_mask);
  // The row stays addressed at the current bucket for the whole search.
  assign v_raddr = (state == B_IDLE) ? pop_data.bucket[BB-1:0] : bucket_q;

  always_ff @(posedge clk) begin
    if (v_we) begin
      vrow_mem[v_waddr] <= v_wdata;
    end
    vrow_rd <= vrow_mem[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      key_mem[wr_slot] <= key_q;
      id_mem[wr_slot]  <= next_id;
    end
    key_rd <= key_mem[rd_slot];
    id_rd  <= id_mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_cnt  <= '0;
      next_id  <= '0;
      done     <= 1'b0;
      chk_pend <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        next_id <= cfg_data;
      end
      unique case (state)
        B_CLEAR: begin
          clr_cnt <= clr_cnt + BB'(1);
          if (clr_cnt == BB'(BUCKETS - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (pop_valid) begin
            key_q    <= pop_data.key;
            code_q   <= pop_data.code;
            bucket_q <= pop_data.bucket[BB-1:0];
            iw       <= '0;
            chk_pend <= 1'b0;
            state    <= B_SCAN;
          end
        end
        B_SCAN: begin
          if (hit) begin
            result.mapped_id   <= trunc_id(id_rd, code_q);
            result.is_new      <= 1'b0;
            result.bucket_full <= 1'b0;
            done               <= 1'b1;
            state              <= B_IDLE;
          end else if (miss_now) begin
            if (free_found) begin
              result.mapped_id   <= trunc_id(next_id, code_q);
              result.is_new      <= 1'b1;
              result.bucket_full <= 1'b0;
              next_id            <= next_id + ID_W'(1);
            end else begin
              result.mapped_id   <= '0;
              result.is_new      <= 1'b0;
              result.bucket_full <= 1'b1;
            end
            done  <= 1'b1;
            state <= B_IDLE;
          end else begin
            // Issue the read of one way; its data is compared next cycle.
            iw       <= iw + WCW'(1);
            chk_pend <= 1'b1;
            chk_way  <= way_sel;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_done_gap: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("two results in consecutive cycles");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.is_new && result.bucket_full))
    else $error("new entry and full bucket reported together");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.bucket_full) |-> (result.mapped_id == '0))
    else $error("full bucket result carries a nonzero id");

  a_no_result_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |=> !done)
    else $error("result produced out of the clearing pass");

endmodule

`default_nettype wire

// ----- rtl/sequential_id_mapper.sv -----
// Top level of the sequential id mapper: front, queue and back joined.
// Uses smap_pkg, smap_front, smap_fifo and smap_back.
//
//   Channel   Handshake              Payload
//   item      start / busy           item   (in_item_t: key_bits, field_width)
//   result    done (strobe)          result (out_item_t: mapped_id, is_new, bucket_full)
//   config    cfg_valid / cfg_ready  cfg_data (first_id; also reloads the id counter)
//
// The front takes an item and holds busy until it has pushed the bucket index; when
// BUCKETS is a power of two the index is the low key bits, else a reciprocal-multiply
// remainder unit works it out: quotient estimate, remainder estimate, correction.
// The back takes an item off the queue, then reads the key store one way a cycle
// until a hit or the last way is read; the result is registered.
// After reset the valid rows are cleared row by row with busy held high.
// Results cannot be held off; a two-item queue lets the front run ahead.
`default_nettype none

module sequential_id_mapper #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  smap_pkg::in_item_t  item,
  output logic                done,
  output smap_pkg::out_item_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);
  import smap_pkg::*;

  job_t push_data;
  job_t pop_data;
  logic push_valid;
  logic push_ready;
  logic pop_valid;
  logic pop_ready;
  logic clearing;

  assign cfg_ready = 1'b1;

  smap_front #(
    .BUCKETS(BUCKETS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .hold      (clearing),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  smap_fifo #(
    .WIDTH($bits(job_t))
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  smap_back #(
    .BUCKETS(BUCKETS),
    .WAYS   (WAYS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data (pop_data),
    .cfg_write(cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .clearing (clearing),
    .done     (done),
    .result   (result)
  );

endmodule

`default_nettype wire
